[rtl/pru_pkg.sv]
// Shared types, constants and helpers of the pixel replication upscale addresser.
package pru_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int MAX_FACTOR  = 8;

    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;
    localparam int FACT_W      = 4;
    localparam int PITCH_W     = 14;
    localparam int OFF_W       = 26;
    localparam int PIX_W       = 24;
    localparam int BASE_W      = POS_W + FACT_W;
    localparam int DIVR_W      = DIM_W + 3;
    localparam int CFG_IDX_W   = 2;

    localparam int QUEUE_DEPTH = 4;

    localparam int S_TDATA_W   = ((PIX_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = PIX_W + 2 * POS_W + OFF_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_TARGET_WIDTH  = 2'd2,
        CFG_TARGET_HEIGHT = 2'd3
    } cfg_index_t;

    // derived scaling setup, shared by front and back
    typedef struct packed {
        logic [DIM_W-1:0]   src_w;
        logic [DIM_W-1:0]   src_h;
        logic [FACT_W-1:0]  wf;
        logic [FACT_W-1:0]  hf;
        logic [PITCH_W-1:0] pitch;
        logic               size_err;
        logic               busy;
    } scale_cfg_t;

    // one classified pixel waiting for replication
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic               err;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [OFF_W-1:0]   row_off;
        logic [OFF_W-1:0]   col_off;
    } queue_entry_t;

    // zero acts as one, oversize clamps to the largest image
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] x);
        logic [DIM_W-1:0] r;
        if (x == '0) begin
            r = DIM_W'(1);
        end else if (x > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

[rtl/pru_cfg.sv]
// Dimension registers and the iterative ratio logic that computes both scale factors in parallel.
module pru_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pru_pkg::DIM_W-1:0]      cfg_wdata,
    output pru_pkg::scale_cfg_t            cfg
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV} state_t;

    state_t                          state_reg;
    logic [pru_pkg::DIM_W-1:0]       sw_reg, sh_reg, tw_reg, th_reg;
    logic [pru_pkg::DIVR_W-1:0]      rem_w_reg, rem_h_reg;
    logic [pru_pkg::DIM_W-1:0]       dvs_w_reg, dvs_h_reg;
    logic [pru_pkg::FACT_W-1:0]      qw_reg, qh_reg;
    logic [1:0]                      step_reg;
    logic [pru_pkg::FACT_W-1:0]      wf_reg, hf_reg;
    logic [pru_pkg::PITCH_W-1:0]     pitch_reg;
    logic                            err_reg;

    logic [pru_pkg::DIM_W-1:0]       sw_eff, sh_eff, tw_eff, th_eff;
    logic [pru_pkg::DIVR_W-1:0]      trial_w, trial_h;
    logic                            ge_w, ge_h;
    logic [pru_pkg::FACT_W-1:0]      bit_q, qw_next, qh_next;
    logic [pru_pkg::PITCH_W-1:0]     tw3;

    assign sw_eff = pru_pkg::eff_dim(sw_reg);
    assign sh_eff = pru_pkg::eff_dim(sh_reg);
    assign tw_eff = pru_pkg::eff_dim(tw_reg);
    assign th_eff = pru_pkg::eff_dim(th_reg);

    // one quotient bit per cycle, msb first
    assign trial_w = pru_pkg::DIVR_W'(dvs_w_reg) << step_reg;
    assign trial_h = pru_pkg::DIVR_W'(dvs_h_reg) << step_reg;
    assign ge_w    = rem_w_reg >= trial_w;
    assign ge_h    = rem_h_reg >= trial_h;
    assign bit_q   = pru_pkg::FACT_W'(1) << step_reg;
    assign qw_next = ge_w ? (qw_reg | bit_q) : qw_reg;
    assign qh_next = ge_h ? (qh_reg | bit_q) : qh_reg;

    // width*3 + 3, low two bits cleared (rounds up to a multiple of four)
    assign tw3 = (pru_pkg::PITCH_W'(tw_eff) << 1) + pru_pkg::PITCH_W'(tw_eff)
               + pru_pkg::PITCH_W'(3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sw_reg    <= pru_pkg::DIM_W'(1);
            sh_reg    <= pru_pkg::DIM_W'(1);
            tw_reg    <= pru_pkg::DIM_W'(1);
            th_reg    <= pru_pkg::DIM_W'(1);
            wf_reg    <= pru_pkg::FACT_W'(1);
            hf_reg    <= pru_pkg::FACT_W'(1);
            pitch_reg <= pru_pkg::PITCH_W'(4);
            err_reg   <= 1'b0;
            step_reg  <= 2'd0;
        end else if (cfg_wr_en) begin
            unique case (pru_pkg::cfg_index_t'(cfg_index))
                pru_pkg::CFG_SOURCE_WIDTH:  sw_reg <= cfg_wdata;
                pru_pkg::CFG_SOURCE_HEIGHT: sh_reg <= cfg_wdata;
                pru_pkg::CFG_TARGET_WIDTH:  tw_reg <= cfg_wdata;
                pru_pkg::CFG_TARGET_HEIGHT: th_reg <= cfg_wdata;
                default: ;
            endcase
            state_reg <= ST_LOAD;
        end else begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_LOAD: begin
                    rem_w_reg <= pru_pkg::DIVR_W'(tw_eff);
                    rem_h_reg <= pru_pkg::DIVR_W'(th_eff);
                    dvs_w_reg <= sw_eff;
                    dvs_h_reg <= sh_eff;
                    qw_reg    <= '0;
                    qh_reg    <= '0;
                    step_reg  <= 2'd3;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (ge_w) rem_w_reg <= rem_w_reg - trial_w;
                    if (ge_h) rem_h_reg <= rem_h_reg - trial_h;
                    qw_reg <= qw_next;
                    qh_reg <= qh_next;
                    if (step_reg == 2'd0) begin
                        wf_reg <= (qw_next > pru_pkg::FACT_W'(pru_pkg::MAX_FACTOR)) ?
                                  pru_pkg::FACT_W'(pru_pkg::MAX_FACTOR) : qw_next;
                        hf_reg <= (qh_next > pru_pkg::FACT_W'(pru_pkg::MAX_FACTOR)) ?
                                  pru_pkg::FACT_W'(pru_pkg::MAX_FACTOR) : qh_next;
                        pitch_reg <= {tw3[pru_pkg::PITCH_W-1:2], 2'b00};
                        err_reg   <= (tw_eff < sw_eff) || (th_eff < sh_eff);
                        state_reg <= ST_IDLE;
                    end else begin
                        step_reg <= step_reg - 2'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cfg.src_w    = sw_eff;
        cfg.src_h    = sh_eff;
        cfg.wf       = wf_reg;
        cfg.hf       = hf_reg;
        cfg.pitch    = pitch_reg;
        cfg.size_err = err_reg;
        cfg.busy     = (state_reg != ST_IDLE);
    end

endmodule

[rtl/pru_front.sv]
// Input side: position tracking, base address of each pixel's block, queue push.
module pru_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pru_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                     s_tuser,
    input  pru_pkg::scale_cfg_t            cfg,
    output logic                           q_push,
    output pru_pkg::queue_entry_t          q_entry,
    input  logic                           q_full
);

    localparam int PROD_W = pru_pkg::BASE_W + pru_pkg::PITCH_W;

    logic [pru_pkg::POS_W-1:0]   sc_reg, sr_reg, sc_next, sr_next;
    logic                        st_valid_reg, st_valid_next;
    logic [pru_pkg::PIX_W-1:0]   st_pix_reg;
    logic                        st_err_reg;
    logic [pru_pkg::BASE_W-1:0]  st_bcol_reg, st_brow_reg;

    logic                        accept;
    logic [pru_pkg::POS_W-1:0]   sc_eff, sr_eff;
    logic [pru_pkg::DIM_W-1:0]   c1, r1, r_sel;
    logic [PROD_W-1:0]           row_prod;

    assign s_tready = !cfg.busy && (!st_valid_reg || !q_full);
    assign accept   = s_tvalid && s_tready;
    assign q_push   = st_valid_reg && !q_full;

    assign sc_eff = s_tuser[0] ? '0 : sc_reg;
    assign sr_eff = s_tuser[0] ? '0 : sr_reg;

    // advance column, wrap into row, wrap row
    always_comb begin
        c1 = pru_pkg::DIM_W'(sc_eff) + pru_pkg::DIM_W'(1);
        r1 = pru_pkg::DIM_W'(sr_eff) + pru_pkg::DIM_W'(1);
        if (c1 >= cfg.src_w) begin
            sc_next = '0;
            r_sel   = (r1 >= cfg.src_h) ? '0 : r1;
        end else begin
            sc_next = c1[pru_pkg::POS_W-1:0];
            r_sel   = pru_pkg::DIM_W'(sr_eff);
        end
        sr_next = (r_sel >= cfg.src_h) ? '0 : r_sel[pru_pkg::POS_W-1:0];
    end

    always_comb begin
        if (accept) st_valid_next = 1'b1;
        else if (q_push) st_valid_next = 1'b0;
        else st_valid_next = st_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg       <= '0;
            sr_reg       <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            if (accept) begin
                sc_reg <= sc_next;
                sr_reg <= sr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_pix_reg  <= s_tdata[pru_pkg::PIX_W-1:0];
            st_err_reg  <= cfg.size_err;
            st_bcol_reg <= pru_pkg::BASE_W'(sc_eff) * pru_pkg::BASE_W'(cfg.wf);
            st_brow_reg <= pru_pkg::BASE_W'(sr_eff) * pru_pkg::BASE_W'(cfg.hf);
        end
    end

    assign row_prod = PROD_W'(st_brow_reg) * PROD_W'(cfg.pitch);

    always_comb begin
        q_entry.pix     = st_pix_reg;
        q_entry.err     = st_err_reg;
        q_entry.col     = st_bcol_reg[pru_pkg::POS_W-1:0];
        q_entry.row     = st_brow_reg[pru_pkg::POS_W-1:0];
        q_entry.row_off = row_prod[pru_pkg::OFF_W-1:0];
        q_entry.col_off = (pru_pkg::OFF_W'(st_bcol_reg) << 1) + pru_pkg::OFF_W'(st_bcol_reg);
    end

endmodule

[rtl/pru_queue.sv]
// Small register queue between the front and the replication back end.
module pru_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  pru_pkg::queue_entry_t   entry_in,
    output logic                    full,
    input  logic                    pop,
    output pru_pkg::queue_entry_t   entry_out,
    output logic                    empty
);

    localparam int DEPTH = pru_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pru_pkg::queue_entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]       wptr_reg, rptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign entry_out = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wptr_reg] <= entry_in;
    end

endmodule

[rtl/pru_back.sv]
// Output side: walks the factor block of each queued pixel, one copy per cycle while m_tready is high.
module pru_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pru_pkg::scale_cfg_t            cfg,
    input  logic                           q_empty,
    input  pru_pkg::queue_entry_t          q_entry,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pru_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast
);

    logic                         valid_reg, valid_next;
    logic                         run_reg, run_next;
    logic [pru_pkg::FACT_W-1:0]   h_reg, h_next, v_reg, v_next;
    logic [pru_pkg::PIX_W-1:0]    pix_reg, pix_next;
    logic [pru_pkg::POS_W-1:0]    col_reg, col_next, row_reg, row_next;
    logic [pru_pkg::POS_W-1:0]    bcol_reg, bcol_next;
    logic [pru_pkg::OFF_W-1:0]    off_reg, off_next, rso_reg, rso_next;
    logic                         err_reg, err_next;
    logic                         last_reg, last_next;

    logic                         advance, h_end;
    logic [pru_pkg::OFF_W-1:0]    first_off;

    assign advance   = !valid_reg || m_tready;
    assign q_pop     = advance && !run_reg && !q_empty;
    assign h_end     = (h_reg == cfg.wf - pru_pkg::FACT_W'(1));
    assign first_off = q_entry.row_off + q_entry.col_off;

    always_comb begin
        valid_next = valid_reg;
        run_next   = run_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        pix_next   = pix_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        bcol_next  = bcol_reg;
        off_next   = off_reg;
        rso_next   = rso_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        if (advance) begin
            if (run_reg) begin
                valid_next = 1'b1;
                if (!h_end) begin
                    h_next   = h_reg + pru_pkg::FACT_W'(1);
                    col_next = col_reg + pru_pkg::POS_W'(1);
                    off_next = off_reg + pru_pkg::OFF_W'(3);
                end else begin
                    h_next   = '0;
                    v_next   = v_reg + pru_pkg::FACT_W'(1);
                    col_next = bcol_reg;
                    row_next = row_reg + pru_pkg::POS_W'(1);
                    rso_next = rso_reg + pru_pkg::OFF_W'(cfg.pitch);
                    off_next = rso_reg + pru_pkg::OFF_W'(cfg.pitch);
                end
                last_next = (h_next == cfg.wf - pru_pkg::FACT_W'(1)) &&
                            (v_next == cfg.hf - pru_pkg::FACT_W'(1));
                run_next  = !last_next;
            end else if (!q_empty) begin
                valid_next = 1'b1;
                h_next     = '0;
                v_next     = '0;
                err_next   = q_entry.err;
                if (q_entry.err) begin
                    // invalid size: single zeroed result
                    pix_next  = '0;
                    col_next  = '0;
                    row_next  = '0;
                    off_next  = '0;
                    last_next = 1'b1;
                end else begin
                    pix_next  = q_entry.pix;
                    col_next  = q_entry.col;
                    row_next  = q_entry.row;
                    off_next  = first_off;
                    last_next = (cfg.wf == pru_pkg::FACT_W'(1)) &&
                                (cfg.hf == pru_pkg::FACT_W'(1));
                end
                bcol_next = q_entry.col;
                rso_next  = first_off;
                run_next  = !last_next;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            run_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg    <= h_next;
        v_reg    <= v_next;
        pix_reg  <= pix_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        bcol_reg <= bcol_next;
        off_reg  <= off_next;
        rso_reg  <= rso_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {{pru_pkg::M_PAD_W{1'b0}}, off_reg, row_reg, col_reg, pix_reg};
    assign m_tuser[0] = err_reg;
    assign m_tlast    = last_reg;

endmodule

[rtl/pixel_replication_upscale_addresser_unit.sv]
// Top level of the pixel replication upscale addresser: config, front, queue, back.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata[23:0] pixel_value, s_tuser[0] image_start
//  m_       out  m_tvalid/m_tready    m_tdata pixel/column/row/offset, m_tuser[0] size_error,
//                                     m_tlast run_last
//  cfg_     in   cfg_wr_en            cfg_index register, cfg_wdata value
//
//  Each pixel gives wf*hf copies at the back end (one copy per cycle while m_tready is high),
//  a single copy for a size error. The first copy passes the front stage register, the queue
//  and the back end's output register before it is valid; a four-entry queue lets the
//  input run ahead during long runs.
//  Every register write restarts the factor divider, with s_tready held low while it runs.
//  Reset is synchronous, active low; factors come up at 1, pitch at 4.
//  A stalled m_ side fills the queue, then holds s_tready low; no transfer is dropped.
module pixel_replication_upscale_addresser_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_wr_en,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pru_pkg::DIM_W-1:0]      cfg_wdata,
    // source pixels
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pru_pkg::S_TDATA_W-1:0]  s_tdata,   // [23:0] pixel_value
    input  logic [0:0]                     s_tuser,   // [0] image_start
    // replicated copies
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pru_pkg::M_TDATA_W-1:0]  m_tdata,   // [23:0] out_pixel, [35:24] dest_column,
                                                      // [47:36] dest_row, [73:48] byte_offset
    output logic [0:0]                     m_tuser,   // [0] size_error
    output logic                           m_tlast    // run_last
);

    pru_pkg::scale_cfg_t    cfg;
    pru_pkg::queue_entry_t  push_entry, head_entry;
    logic                   q_push, q_full, q_pop, q_empty;

    // registers plus factor / pitch recompute
    pru_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // position tracking, block base address
    pru_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_push   (q_push),
        .q_entry  (push_entry),
        .q_full   (q_full)
    );

    pru_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .entry_in  (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .entry_out (head_entry),
        .empty     (q_empty)
    );

    // copy walker, h fastest then v
    pru_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/pru_checker.sv]
// Port-level checks of the upscale addresser, bound to the top level.
module pru_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pru_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                     m_tuser,
    input logic                           m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // size error is a single zeroed copy
    a_err_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("size error result not a lone zero copy");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // factor recompute blocks input
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && cfg_wr_en |=> !s_tready)
        else $error("input taken during factor recompute");

endmodule

bind pixel_replication_upscale_addresser_unit pru_checker u_pru_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);
